// ===== src/tkes_pkg.sv =====
// ----------------------------------------------------------------------------
// tkes_pkg: shared types and constants of the touch key event scanner
// Holds the pad reorder table, the key phase codes, the register indexes and
// the records that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package tkes_pkg;

	localparam int NUM_PADS = 16;
	localparam int NUM_KEYS = 8;

	// The bit read on pulse n lands at pad position PAD_MAP[n].
	localparam logic [3:0] PAD_MAP [NUM_PADS] = '{
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
		4'd12, 4'd13, 4'd14, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3
	};

	// Key phases.
	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PRESSED  = 2'd1;
	localparam logic [1:0] PH_ACTIVE   = 2'd2;
	localparam logic [1:0] PH_RELEASED = 2'd3;

	// Configuration register indexes.
	localparam logic REG_RELEASE_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD             = 1'b1;

	localparam logic [15:0] RELEASE_DEBOUNCE_RESET = 16'd10;
	localparam logic [15:0] HOLD_RESET             = 16'd500;

	// A changed scan waiting for the key sequencer.
	typedef struct packed {
		logic [NUM_KEYS-1:0] keys;
		logic [31:0]         now_ms;
	} tkes_job_t;

	// One key event.
	typedef struct packed {
		logic [2:0] key_index;
		logic [1:0] key_state;
		logic       hold;
		logic       last;
	} tkes_event_t;

endpackage

// ===== src/tkes_front.sv =====
// ----------------------------------------------------------------------------
// tkes_front: scan intake
// Reorders the pad bits, compares them with the stored pads and hands a
// changed scan, merged into key bits, to the queue.
// ----------------------------------------------------------------------------
module tkes_front
	import tkes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        scan_valid,
	output logic        scan_ready,
	input  logic [15:0] sample_bits,
	input  logic [31:0] now_ms,
	input  logic        queue_full,
	output logic        push,
	output tkes_job_t   push_job
);

	logic [NUM_PADS-1:0] raw_pads_q;
	logic [NUM_PADS-1:0] pads;
	logic                changed;
	logic                accept;

	always_comb begin
		pads = '0;
		for (int n = 0; n < NUM_PADS; n++) begin
			pads[PAD_MAP[n]] = sample_bits[n];
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			push_job.keys[k] = pads[2*k] | pads[2*k+1];
		end
		push_job.now_ms = now_ms;
	end

	assign changed    = (pads != raw_pads_q);
	assign scan_ready = !queue_full;
	assign accept     = scan_valid && scan_ready;
	assign push       = accept && changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_pads_q <= '0;
		end else if (push) begin
			raw_pads_q <= pads;
		end
	end

endmodule

// ===== src/tkes_queue.sv =====
// ----------------------------------------------------------------------------
// tkes_queue: job queue
// A short register queue that decouples scan intake from key sequencing.
// ----------------------------------------------------------------------------
module tkes_queue
	import tkes_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tkes_job_t push_job,
	output logic      full,
	output logic      pop_valid,
	input  logic      pop,
	output tkes_job_t pop_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tkes_job_t        slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;
	assign pop_job   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== src/tkes_back.sv =====
// ----------------------------------------------------------------------------
// tkes_back: key sequencer
// Steps the eight keys of one changed scan, one key per cycle while the output
// register is free, and delivers the events through that register. One event
// is held back so that the final event of the scan can be marked.
// ----------------------------------------------------------------------------
module tkes_back
	import tkes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] release_debounce_ms,
	input  logic [15:0] hold_ms,
	input  logic        job_valid,
	output logic        job_pop,
	input  tkes_job_t   job,
	output logic        event_valid,
	input  logic        event_ready,
	output tkes_event_t event_out
);

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_STEP  = 2'd1;
	localparam logic [1:0] BK_FLUSH = 2'd2;

	logic [1:0]  state_q;
	logic [2:0]  key_cnt_q;
	tkes_job_t   job_q;

	logic [1:0]  key_phase_q [NUM_KEYS];
	logic        key_hold_q  [NUM_KEYS];
	logic [31:0] key_stamp_q [NUM_KEYS];

	tkes_event_t pend_q;
	logic        pend_valid_q;
	tkes_event_t out_q;
	logic        out_valid_q;

	logic        out_free;
	logic        step_en;
	logic        flush_en;
	logic        load_out;

	logic        p;
	logic [1:0]  ph_mid;
	logic        hold_mid;
	logic [31:0] elapsed;
	logic [1:0]  ph_new;
	logic        hold_new;
	logic        stamp_new;
	logic        fire;

	assign out_free = !out_valid_q || event_ready;
	assign job_pop  = (state_q == BK_IDLE) && job_valid;
	assign step_en  = (state_q == BK_STEP) && out_free;
	assign flush_en = (state_q == BK_FLUSH) && out_free;
	assign load_out = pend_valid_q && ((step_en && fire) || flush_en);

	// Phase update of the current key.
	always_comb begin
		p        = job_q.keys[key_cnt_q];
		ph_mid   = key_phase_q[key_cnt_q];
		hold_mid = key_hold_q[key_cnt_q];
		if (ph_mid == PH_PRESSED) begin
			ph_mid = PH_ACTIVE;
		end
		if (ph_mid == PH_RELEASED) begin
			ph_mid   = PH_IDLE;
			hold_mid = 1'b0;
		end
		elapsed   = job_q.now_ms - key_stamp_q[key_cnt_q];
		ph_new    = ph_mid;
		hold_new  = hold_mid;
		stamp_new = 1'b0;
		fire      = 1'b0;
		if (ph_mid == PH_IDLE && p) begin
			ph_new    = PH_PRESSED;
			stamp_new = 1'b1;
			fire      = 1'b1;
		end else if (ph_mid == PH_ACTIVE && !p && elapsed > {16'd0, release_debounce_ms}) begin
			ph_new    = PH_RELEASED;
			stamp_new = 1'b1;
			fire      = 1'b1;
		end else if (ph_mid == PH_ACTIVE && !hold_mid && elapsed > {16'd0, hold_ms}) begin
			hold_new = 1'b1;
			fire     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			key_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_phase_q[k] <= PH_IDLE;
				key_hold_q[k]  <= 1'b0;
				key_stamp_q[k] <= '0;
			end
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (job_valid) begin
						state_q   <= BK_STEP;
						key_cnt_q <= '0;
					end
				end
				BK_STEP: begin
					if (step_en) begin
						key_phase_q[key_cnt_q] <= ph_new;
						key_hold_q[key_cnt_q]  <= hold_new;
						if (stamp_new) begin
							key_stamp_q[key_cnt_q] <= job_q.now_ms;
						end
						if (fire) begin
							pend_valid_q <= 1'b1;
						end
						key_cnt_q <= key_cnt_q + 1'b1;
						if (key_cnt_q == 3'(NUM_KEYS - 1)) begin
							state_q <= BK_FLUSH;
						end
					end
				end
				BK_FLUSH: begin
					if (flush_en) begin
						pend_valid_q <= 1'b0;
						state_q      <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (event_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (step_en && fire) begin
			pend_q.key_index <= key_cnt_q;
			pend_q.key_state <= ph_new;
			pend_q.hold      <= hold_new;
			pend_q.last      <= 1'b0;
		end
		if (load_out) begin
			out_q.key_index <= pend_q.key_index;
			out_q.key_state <= pend_q.key_state;
			out_q.hold      <= pend_q.hold;
			out_q.last      <= flush_en;
		end
	end

	assign event_valid = out_valid_q;
	assign event_out   = out_q;

endmodule

// ===== src/touch_key_event_scanner.sv =====
// ----------------------------------------------------------------------------
// touch_key_event_scanner: touch key event scanner top level
// Turns scans of sixteen touch pads into press, hold and release events of
// eight merged keys, with an APB-style port for the two timing registers.
// ----------------------------------------------------------------------------
// Usage. The scan channel (scan_valid, scan_ready, sample_bits, now_ms) takes
// one scan per request. A scan whose reordered pads equal the stored pads is
// taken and produces nothing. A changed scan is queued and the key sequencer
// then visits the eight keys, one key per cycle while the output register is
// free, so a changed scan occupies the sequencer for a load step, eight key
// steps and a step to mark the final event. The sequencer takes a new scan
// only when done with the last, which sets the sustained rate of changed
// scans; the queue of QUEUE_DEPTH scans lets intake run ahead meanwhile.
// The event channel (event_valid, event_ready, key_index, key_state, hold,
// last) delivers zero to eight requests per changed scan in ascending key
// order; last marks the final one. Each event is held back until the next
// event of the scan is found or the last key has been visited. If the
// receiver stalls, the output register holds its request, the sequencer
// waits, the queue fills and scan_ready drops. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
// Reset clears the stored pads, all keys to idle with hold clear and stamp
// zero, and the registers to 10 ms debounce and 500 ms hold time.
// ----------------------------------------------------------------------------
module touch_key_event_scanner
	import tkes_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Scan channel
	input  logic        scan_valid,
	output logic        scan_ready,
	input  logic [15:0] sample_bits,
	input  logic [31:0] now_ms,
	// Event channel
	output logic        event_valid,
	input  logic        event_ready,
	output logic [2:0]  key_index,
	output logic [1:0]  key_state,
	output logic        hold,
	output logic        last
);

	logic [15:0] release_debounce_q;
	logic [15:0] hold_ms_q;
	logic        cfg_write;

	logic        queue_full;
	logic        push;
	tkes_job_t   push_job;
	logic        job_valid;
	logic        job_pop;
	tkes_job_t   job;
	tkes_event_t event_out;

	// Both registers are 16 bits at byte addresses 0 and 4; address bit 2
	// selects the register and the low address bits are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_debounce_q <= RELEASE_DEBOUNCE_RESET;
			hold_ms_q          <= HOLD_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_RELEASE_DEBOUNCE) begin
				release_debounce_q <= pwdata[15:0];
			end else begin
				hold_ms_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_HOLD) ? {16'd0, hold_ms_q} : {16'd0, release_debounce_q};

	// Front end: reorder, compare with the stored pads, merge into keys.
	tkes_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan_valid  (scan_valid),
		.scan_ready  (scan_ready),
		.sample_bits (sample_bits),
		.now_ms      (now_ms),
		.queue_full  (queue_full),
		.push        (push),
		.push_job    (push_job)
	);

	// Queue of changed scans between intake and sequencing.
	tkes_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop_valid (job_valid),
		.pop       (job_pop),
		.pop_job   (job)
	);

	// Back end: per-key phase update and event delivery.
	tkes_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.release_debounce_ms (release_debounce_q),
		.hold_ms             (hold_ms_q),
		.job_valid           (job_valid),
		.job_pop             (job_pop),
		.job                 (job),
		.event_valid         (event_valid),
		.event_ready         (event_ready),
		.event_out           (event_out)
	);

	assign key_index = event_out.key_index;
	assign key_state = event_out.key_state;
	assign hold      = event_out.hold;
	assign last      = event_out.last;

endmodule

// ===== src/tkes_checker.sv =====
// ----------------------------------------------------------------------------
// tkes_checker: port-level checks of the touch key event scanner
// Watches the event channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tkes_checker
	import tkes_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       event_valid,
	input logic       event_ready,
	input logic [2:0] key_index,
	input logic [1:0] key_state,
	input logic       hold,
	input logic       last
);

	// A stalled event keeps its request unchanged.
	a_event_stable: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_ready |=> event_valid && $stable(key_index)
		&& $stable(key_state) && $stable(hold) && $stable(last))
		else $error("event request changed while stalled");

	// Keys never report a transition into idle.
	a_no_idle_event: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> key_state != PH_IDLE)
		else $error("event with idle state");

	// A fresh press always starts with the hold flag clear.
	a_press_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && key_state == PH_PRESSED |-> !hold)
		else $error("press event with hold set");

	// An event of an active key is only ever the hold event.
	a_active_is_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && key_state == PH_ACTIVE |-> hold)
		else $error("active event without hold");

endmodule

bind touch_key_event_scanner tkes_checker u_tkes_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.event_valid (event_valid),
	.event_ready (event_ready),
	.key_index   (key_index),
	.key_state   (key_state),
	.hold        (hold),
	.last        (last)
);
